// ----- hw/rtl/phib_pkg.sv -----
// Shared types, codes and defaults for the pad input history buffer.
// Depends on nothing; imported by the ring memory and the top level.
package phib_pkg;

    localparam int SLOT_COUNT_DEF    = 4;
    localparam int HISTORY_DEPTH_DEF = 64;
    localparam int READ_BURST_MAX    = 64;

    localparam logic [31:0] FREE_ID      = 32'hFFFF_FFFF;
    localparam logic [47:0] DEFAULT_AXES = 48'h0000_8080_8080;

    localparam logic [31:0] HOST_ID_RST = 32'h7FFF_FFFF;
    localparam logic [31:0] L2_MASK_RST = 32'd256;
    localparam logic [31:0] R2_MASK_RST = 32'd512;

    // Operation codes carried in the mode field
    localparam logic [2:0] MODE_CONNECT    = 3'd0;
    localparam logic [2:0] MODE_DISCONNECT = 3'd1;
    localparam logic [2:0] MODE_BUTTON     = 3'd2;
    localparam logic [2:0] MODE_AXIS       = 3'd3;
    localparam logic [2:0] MODE_RESET      = 3'd4;
    localparam logic [2:0] MODE_READ       = 3'd5;
    localparam logic [2:0] MODE_SPARE6     = 3'd6;
    localparam logic [2:0] MODE_SPARE7     = 3'd7;

    // Axis codes with side effects on the button bits
    localparam logic [2:0] AXIS_L2  = 3'd4;
    localparam logic [2:0] AXIS_R2  = 3'd5;
    localparam logic [2:0] AXIS_MAX = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_HOST_ID = 2'd0;
    localparam logic [1:0] CFG_L2_MASK = 2'd1;
    localparam logic [1:0] CFG_R2_MASK = 2'd2;

    localparam logic KIND_STATE   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] device_id;
        logic [2:0]         slot_index;
        logic [31:0]        button_mask;
        logic               button_down;
        logic [2:0]         axis_index;
        logic [7:0]         axis_value;
        logic [63:0]        event_time;
        logic [6:0]         read_limit;
    } in_word_t;

    typedef struct packed {
        logic        kind;
        logic        connected;
        logic [2:0]  present_count;
        logic [63:0] state_time;
        logic [31:0] buttons;
        logic [47:0] axes_packed;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic [63:0] state_time;
        logic [31:0] buttons;
        logic [47:0] axes;
    } entry_t;

endpackage

// ----- hw/rtl/phib_ring_mem.sv -----
// History ring storage for all slots: one write port, one registered read port.
// Depends on phib_pkg for the entry type.
module phib_ring_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  phib_pkg::entry_t    wr_data,
    input  logic [AW-1:0]       rd_addr,
    output phib_pkg::entry_t    rd_data
);
    import phib_pkg::*;

    entry_t mem [DEPTH];

    // Write on enable, read every cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- hw/rtl/pad_input_history_buffer.sv -----
// Top level of the pad input history buffer: slot table, sequencer, output word.
// Depends on phib_pkg and phib_ring_mem.
//
//  channel | ports                           | direction
//  input   | s_valid s_ready s_data          | in
//  result  | m_valid m_ready m_data          | out
//  config  | cfg_wr_en cfg_index cfg_wdata   | in
//
// Connect, disconnect, button, axis and reset are accepted, then executed.
// A read of the last state or a summary is accepted, decoded and then output,
// and the output is held through any output stall.
// A read of n history entries goes accept, decode, then address, data, output per
// entry; the ring port delivers one entry per address, registered, held until taken.
// After reset the init state writes the default slot 0 entry before input is taken.
// A stalled result holds the sequencer; no new word is accepted until the last goes.
module pad_input_history_buffer #(
    parameter int SLOT_COUNT    = phib_pkg::SLOT_COUNT_DEF,
    parameter int HISTORY_DEPTH = phib_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  phib_pkg::in_word_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output phib_pkg::out_word_t  m_data,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_wdata
);
    import phib_pkg::*;

    localparam int SW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int PW    = $clog2(HISTORY_DEPTH);
    localparam int CW    = $clog2(HISTORY_DEPTH + 1);
    localparam int TOTAL = SLOT_COUNT * HISTORY_DEPTH;
    localparam int AW    = $clog2(TOTAL);

    localparam logic [2:0] ST_INIT    = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_DECODE  = 3'd2;
    localparam logic [2:0] ST_RD_ADDR = 3'd3;
    localparam logic [2:0] ST_RD_DATA = 3'd4;
    localparam logic [2:0] ST_OUT     = 3'd5;

    logic [2:0]  state_reg, state_next;
    in_word_t    in_reg, in_next;
    out_word_t   out_reg, out_next;
    logic [31:0] host_reg, l2_reg, r2_reg;

    logic [31:0]   owner_reg [SLOT_COUNT];
    logic [31:0]   owner_next [SLOT_COUNT];
    logic [PW-1:0] head_reg [SLOT_COUNT];
    logic [PW-1:0] head_next [SLOT_COUNT];
    logic [CW-1:0] fill_reg [SLOT_COUNT];
    logic [CW-1:0] fill_next [SLOT_COUNT];
    logic [CW-1:0] rdc_reg [SLOT_COUNT];
    logic [CW-1:0] rdc_next [SLOT_COUNT];
    logic [31:0]   lbtn_reg [SLOT_COUNT];
    logic [31:0]   lbtn_next [SLOT_COUNT];
    logic [47:0]   lax_reg [SLOT_COUNT];
    logic [47:0]   lax_next [SLOT_COUNT];
    logic [63:0]   ltime_reg [SLOT_COUNT];
    logic [63:0]   ltime_next [SLOT_COUNT];

    logic [SW-1:0] rslot_reg, rslot_next;
    logic [CW-1:0] off_reg, off_next;
    logic [6:0]    rem_reg, rem_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    entry_t        mem_wdata, mem_rdata;

    logic [2:0] present;
    logic [CW:0] rd_sum;
    logic [PW-1:0] rd_pos;

    phib_ring_mem #(.DEPTH(TOTAL), .AW(AW)) u_ring (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // Count slot 0 plus bound slots beyond it, saturate at 7
    always_comb begin
        logic [3:0] cnt;
        cnt = 4'd1;
        for (int s = 1; s < SLOT_COUNT; s++) begin
            if (owner_reg[s] != FREE_ID) begin
                cnt = cnt + 4'd1;
            end
        end
        present = (cnt > 4'd7) ? 3'd7 : cnt[2:0];
    end

    // Read address of the current ring entry
    always_comb begin
        rd_sum = (CW+1)'(head_reg[rslot_reg]) + (CW+1)'(off_reg);
        if (rd_sum >= (CW+1)'(HISTORY_DEPTH)) begin
            rd_sum = rd_sum - (CW+1)'(HISTORY_DEPTH);
        end
        rd_pos    = rd_sum[PW-1:0];
        mem_raddr = AW'(rslot_reg) * AW'(HISTORY_DEPTH) + AW'(rd_pos);
    end

    // Sequencer and slot table updates
    always_comb begin
        logic          hit_any, free_any, full, in_range, conn;
        logic [SW-1:0] hit_idx, free_idx, ev, rs;
        logic [31:0]   b;
        logic [47:0]   ax;
        logic [CW:0]   psum;
        logic [PW-1:0] pos;
        logic [6:0]    lim;
        logic [CW-1:0] avail;
        logic [CW:0]   n;

        state_next = state_reg;
        in_next    = in_reg;
        out_next   = out_reg;
        rslot_next = rslot_reg;
        off_next   = off_reg;
        rem_next   = rem_reg;
        owner_next = owner_reg;
        head_next  = head_reg;
        fill_next  = fill_reg;
        rdc_next   = rdc_reg;
        lbtn_next  = lbtn_reg;
        lax_next   = lax_reg;
        ltime_next = ltime_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '{state_time: 64'd0, buttons: 32'd0, axes: DEFAULT_AXES};

        // Owner lookup and lowest free slot
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
            if (owner_reg[s] == in_reg.device_id && in_reg.device_id != FREE_ID) begin
                hit_any = 1'b1;
                hit_idx = SW'(s);
            end
            if (owner_reg[s] == FREE_ID) begin
                free_any = 1'b1;
                free_idx = SW'(s);
            end
        end
        ev = hit_any ? hit_idx : '0;

        // Next state of the event slot
        b  = lbtn_reg[ev];
        ax = lax_reg[ev];
        if (in_reg.mode == MODE_BUTTON) begin
            b = in_reg.button_down ? (b | in_reg.button_mask) : (b & ~in_reg.button_mask);
        end else begin
            for (int k = 0; k < 6; k++) begin
                if (in_reg.axis_index == 3'(k)) begin
                    ax[8*k +: 8] = in_reg.axis_value;
                end
            end
            if (in_reg.axis_index == AXIS_L2) begin
                b = (in_reg.axis_value != 8'd0) ? (b | l2_reg) : (b & ~l2_reg);
            end
            if (in_reg.axis_index == AXIS_R2) begin
                b = (in_reg.axis_value != 8'd0) ? (b | r2_reg) : (b & ~r2_reg);
            end
        end

        // Ring position of a push; a full ring overwrites its oldest entry
        full = (fill_reg[ev] == CW'(HISTORY_DEPTH));
        psum = (CW+1)'(head_reg[ev]) + (CW+1)'(fill_reg[ev]);
        if (psum >= (CW+1)'(HISTORY_DEPTH)) begin
            psum = psum - (CW+1)'(HISTORY_DEPTH);
        end
        pos = full ? head_reg[ev] : psum[PW-1:0];

        // Read target
        in_range = ({1'b0, in_reg.slot_index} < 4'(SLOT_COUNT));
        rs       = in_range ? in_reg.slot_index[SW-1:0] : '0;
        conn     = (in_reg.slot_index == 3'd0) || (in_range && owner_reg[rs] != FREE_ID);
        lim      = (in_reg.read_limit > 7'(READ_BURST_MAX)) ? 7'(READ_BURST_MAX)
                                                            : in_reg.read_limit;
        avail    = fill_reg[rs] - rdc_reg[rs];
        n        = ((CW+1)'(avail) < (CW+1)'(lim)) ? (CW+1)'(avail) : (CW+1)'(lim);

        unique case (state_reg)
            ST_INIT: begin
                // Seed slot 0 with the default state
                mem_we     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    in_next    = s_data;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_IDLE;
                priority case (in_reg.mode)
                    MODE_CONNECT: begin
                        if (in_reg.device_id != host_reg && in_reg.device_id != FREE_ID
                            && !hit_any && free_any) begin
                            owner_next[free_idx] = in_reg.device_id;
                        end
                    end
                    MODE_DISCONNECT: begin
                        if (hit_any) begin
                            owner_next[hit_idx] = FREE_ID;
                            head_next[hit_idx]  = '0;
                            fill_next[hit_idx]  = '0;
                            rdc_next[hit_idx]   = '0;
                            lbtn_next[hit_idx]  = '0;
                            lax_next[hit_idx]   = DEFAULT_AXES;
                            ltime_next[hit_idx] = '0;
                        end
                    end
                    MODE_BUTTON, MODE_AXIS: begin
                        if (in_reg.mode == MODE_BUTTON || in_reg.axis_index <= AXIS_MAX) begin
                            mem_we    = 1'b1;
                            mem_waddr = AW'(ev) * AW'(HISTORY_DEPTH) + AW'(pos);
                            mem_wdata = '{state_time: in_reg.event_time, buttons: b, axes: ax};
                            if (full) begin
                                head_next[ev] = (head_reg[ev] == PW'(HISTORY_DEPTH - 1))
                                              ? '0 : head_reg[ev] + PW'(1);
                                if (rdc_reg[ev] != '0) begin
                                    rdc_next[ev] = rdc_reg[ev] - CW'(1);
                                end
                            end else begin
                                fill_next[ev] = fill_reg[ev] + CW'(1);
                            end
                            lbtn_next[ev]  = b;
                            lax_next[ev]   = ax;
                            ltime_next[ev] = in_reg.event_time;
                        end
                    end
                    MODE_RESET: begin
                        for (int s = 0; s < SLOT_COUNT; s++) begin
                            head_next[s]  = '0;
                            fill_next[s]  = '0;
                            rdc_next[s]   = '0;
                            lbtn_next[s]  = '0;
                            lax_next[s]   = DEFAULT_AXES;
                            ltime_next[s] = '0;
                        end
                        fill_next[0]  = CW'(1);
                        ltime_next[0] = in_reg.event_time;
                        mem_we        = 1'b1;
                        mem_wdata     = '{state_time: in_reg.event_time, buttons: 32'd0,
                                          axes: DEFAULT_AXES};
                    end
                    MODE_READ: begin
                        out_next.kind          = KIND_STATE;
                        out_next.connected     = conn;
                        out_next.present_count = present;
                        out_next.last          = 1'b1;
                        if (in_reg.read_limit == 7'd0) begin
                            out_next.state_time  = in_range ? ltime_reg[rs] : 64'd0;
                            out_next.buttons     = in_range ? lbtn_reg[rs] : 32'd0;
                            out_next.axes_packed = in_range ? lax_reg[rs] : DEFAULT_AXES;
                            out_next.connected   = in_range && conn;
                            state_next           = ST_OUT;
                        end else if (in_range && conn && n != '0) begin
                            rslot_next = rs;
                            off_next   = rdc_reg[rs];
                            rem_next   = 7'(n);
                            state_next = ST_RD_ADDR;
                        end else begin
                            out_next.kind        = KIND_SUMMARY;
                            out_next.state_time  = 64'd0;
                            out_next.buttons     = 32'd0;
                            out_next.axes_packed = 48'd0;
                            state_next           = ST_OUT;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_RD_ADDR: begin
                // Entry address is presented; data arrives next cycle
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                out_next.kind          = KIND_STATE;
                out_next.connected     = 1'b1;
                out_next.present_count = present;
                out_next.state_time    = mem_rdata.state_time;
                out_next.buttons       = mem_rdata.buttons;
                out_next.axes_packed   = mem_rdata.axes;
                out_next.last          = (rem_reg == 7'd1);
                rdc_next[rslot_reg]    = rdc_reg[rslot_reg] + CW'(1);
                off_next               = off_reg + CW'(1);
                rem_next               = rem_reg - 7'd1;
                state_next             = ST_OUT;
            end
            ST_OUT: begin
                // Hold the word until taken
                if (m_ready) begin
                    state_next = out_reg.last ? ST_IDLE : ST_RD_ADDR;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_data  = out_reg;

    // Control state and slot table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            host_reg  <= HOST_ID_RST;
            l2_reg    <= L2_MASK_RST;
            r2_reg    <= R2_MASK_RST;
            for (int s = 0; s < SLOT_COUNT; s++) begin
                owner_reg[s] <= FREE_ID;
                head_reg[s]  <= '0;
                fill_reg[s]  <= (s == 0) ? CW'(1) : '0;
                rdc_reg[s]   <= '0;
                lbtn_reg[s]  <= '0;
                lax_reg[s]   <= DEFAULT_AXES;
                ltime_reg[s] <= '0;
            end
        end else begin
            state_reg <= state_next;
            owner_reg <= owner_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            rdc_reg   <= rdc_next;
            lbtn_reg  <= lbtn_next;
            lax_reg   <= lax_next;
            ltime_reg <= ltime_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_HOST_ID: host_reg <= cfg_wdata;
                    CFG_L2_MASK: l2_reg   <= cfg_wdata;
                    CFG_R2_MASK: r2_reg   <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload and walk registers
    always_ff @(posedge aclk) begin
        in_reg    <= in_next;
        out_reg   <= out_next;
        rslot_reg <= rslot_next;
        off_reg   <= off_next;
        rem_reg   <= rem_next;
    end

endmodule
